[hdl/bba_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Shared constants, payload types, codes and controller/datapath interface.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int BLOCK_BYTES    = 4096;
    localparam int BLK_LOG        = $clog2(BLOCK_BYTES);
    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int NUM_POOLS      = 2;
    localparam int ADDR_W         = 32;
    localparam int BLKS_W         = 13;
    localparam int REQ_W          = 24;
    localparam int BYTES_W        = 25;
    localparam int NEED_W         = REQ_W + 1 - BLK_LOG;
    localparam int CFG_IDX_W      = 2;

    localparam logic [1:0] MARK_FREE  = 2'd0;
    localparam logic [1:0] MARK_TAKEN = 2'd1;
    localparam logic [1:0] MARK_LAST  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POOL0_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL0_BLOCKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POOL1_BASE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POOL1_BLOCKS = 2'd3;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_RANGE   = 2'd1,
        STS_DOUBLE  = 2'd2,
        STS_NOSPACE = 2'd3
    } status_t;

    typedef struct packed {
        command_t          command;
        logic [REQ_W-1:0]  request_bytes;
        logic              want_fast;
        logic [ADDR_W-1:0] chunk_address;
    } in_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  granted_address;
        logic [BYTES_W-1:0] chunk_bytes;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOCATE,
        S_SCAN,
        S_MARK,
        S_WALK,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CAPTURE,
        OP_LOCATE,
        OP_SCAN,
        OP_MARK,
        OP_WALK,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctl_t;

    typedef struct packed {
        logic clr_busy;
        logic scan_found;
        logic scan_end;
        logic mark_done;
        logic walk_end;
        logic out_full;
    } dp_sts_t;

endpackage
`default_nettype wire

[hdl/bba_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Block bitmap allocator controller
// Sequences capture, pool lookup, scan, run marking, walk and result load.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  bba_pkg::command_t in_cmd,
    input  bba_pkg::dp_sts_t  sts,
    output bba_pkg::ctl_t     ctl
);

    bba_pkg::state_t state_reg;
    bba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = bba_pkg::OP_HOLD;
        in_ready   = 1'b0;
        unique case (state_reg)
            bba_pkg::S_IDLE:
            begin
                in_ready = !sts.clr_busy;
                if (in_valid && !sts.clr_busy)
                begin
                    ctl.op = bba_pkg::OP_CAPTURE;
                    unique case (in_cmd) inside
                        bba_pkg::CMD_ALLOC:                     state_next = bba_pkg::S_SCAN;
                        bba_pkg::CMD_FREE, bba_pkg::CMD_QUERY:  state_next = bba_pkg::S_LOCATE;
                        default:                                state_next = bba_pkg::S_DONE;
                    endcase
                end
            end
            bba_pkg::S_LOCATE:
            begin
                ctl.op     = bba_pkg::OP_LOCATE;
                state_next = bba_pkg::S_WALK;
            end
            bba_pkg::S_SCAN:
            begin
                ctl.op = bba_pkg::OP_SCAN;
                if (sts.scan_found)
                begin
                    state_next = bba_pkg::S_MARK;
                end
                else if (sts.scan_end)
                begin
                    state_next = bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_MARK:
            begin
                ctl.op = bba_pkg::OP_MARK;
                if (sts.mark_done)
                begin
                    state_next = bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_WALK:
            begin
                ctl.op = bba_pkg::OP_WALK;
                if (sts.walk_end)
                begin
                    state_next = bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_DONE:
            begin
                if (!sts.out_full)
                begin
                    ctl.op     = bba_pkg::OP_RESULT;
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/bba_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Block bitmap allocator datapath
// Pool registers, mark memories with clearing sweep, scan and walk pipeline.
// ----------------------------------------------------------------------------
module bba_dp #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  bba_pkg::in_t                      in_data,
    input  bba_pkg::ctl_t                     ctl,
    output bba_pkg::dp_sts_t                  sts,
    output logic                              out_valid,
    input  wire                               out_ready,
    output bba_pkg::out_t                     out_data,
    input  wire                               cfg_valid,
    input  wire [bba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [bba_pkg::ADDR_W-1:0]         cfg_data
);

    localparam int IW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = (IW > bba_pkg::NEED_W) ? IW : bba_pkg::NEED_W;
    localparam int AX = bba_pkg::ADDR_W + 1;

    logic [bba_pkg::ADDR_W-1:0] base0_reg;
    logic [bba_pkg::ADDR_W-1:0] base1_reg;
    logic [bba_pkg::BLKS_W-1:0] blocks0_reg;
    logic [bba_pkg::BLKS_W-1:0] blocks1_reg;
    logic [1:0]                 pend_reg;
    logic [AW-1:0]              clr_idx_reg;

    logic [1:0] mem0 [MAX_BLOCKS];
    logic [1:0] mem1 [MAX_BLOCKS];
    logic [1:0] rd0_reg;
    logic [1:0] rd1_reg;

    bba_pkg::in_t               item_reg;
    logic                       pool_reg;
    logic [IW-1:0]              n_reg;
    logic [bba_pkg::NEED_W-1:0] need_reg;
    logic [IW-1:0]              rd_idx_reg;
    logic [IW-1:0]              ev_idx_reg;
    logic                       ev_vld_reg;
    logic [IW-1:0]              run_reg;
    logic [IW-1:0]              first_reg;
    logic [IW-1:0]              last_reg;
    logic [IW-1:0]              mk_idx_reg;
    bba_pkg::status_t           sts_reg;
    logic [bba_pkg::BYTES_W-1:0] bytes_reg;
    logic                       out_valid_reg;
    bba_pkg::out_t              out_data_reg;

    logic [IW-1:0]              eff0;
    logic [IW-1:0]              eff1;
    logic [bba_pkg::BYTES_W-1:0] req_sum;
    logic [bba_pkg::NEED_W-1:0] need_raw;
    logic [bba_pkg::NEED_W-1:0] need_c;
    logic [AX-1:0]              lim0;
    logic [AX-1:0]              lim1;
    logic                       in0;
    logic                       in1;
    logic [bba_pkg::ADDR_W-1:0] off0;
    logic [bba_pkg::ADDR_W-1:0] off1;
    logic                       ok0;
    logic                       ok1;
    logic [1:0]                 mark;
    logic                       issue;
    logic [IW-1:0]              run_inc;
    logic                       found;
    logic [IW-1:0]              first_c;
    logic                       is_free_cmd;
    logic                       walk_stop;
    logic [IW-1:0]              cnt;
    logic                       wr_en;
    logic [IW-1:0]              wr_idx;
    logic [1:0]                 wr_mark;
    logic                       we0;
    logic                       we1;
    logic [AW-1:0]              wa0;
    logic [AW-1:0]              wa1;
    logic [1:0]                 wd0;
    logic [1:0]                 wd1;
    logic [bba_pkg::ADDR_W-1:0] base_sel;
    logic [bba_pkg::ADDR_W-1:0] granted;

    function automatic logic [IW-1:0] eff_f(input logic [bba_pkg::BLKS_W-1:0] b);
        return (32'(b) > 32'(MAX_BLOCKS)) ? IW'(MAX_BLOCKS) : IW'(b);
    endfunction

    assign eff0 = eff_f(blocks0_reg);
    assign eff1 = eff_f(blocks1_reg);

    assign req_sum  = {1'b0, in_data.request_bytes} + bba_pkg::BYTES_W'(bba_pkg::BLOCK_BYTES - 1);
    assign need_raw = req_sum[bba_pkg::BYTES_W-1:bba_pkg::BLK_LOG];
    assign need_c   = (need_raw == '0) ? bba_pkg::NEED_W'(1) : need_raw;

    assign lim0 = {1'b0, base0_reg} + (AX'(eff0) << bba_pkg::BLK_LOG);
    assign lim1 = {1'b0, base1_reg} + (AX'(eff1) << bba_pkg::BLK_LOG);
    assign in0  = (item_reg.chunk_address >= base0_reg) && ({1'b0, item_reg.chunk_address} <= lim0);
    assign in1  = (item_reg.chunk_address >= base1_reg) && ({1'b0, item_reg.chunk_address} <= lim1);
    assign off0 = (item_reg.chunk_address - base0_reg) >> bba_pkg::BLK_LOG;
    assign off1 = (item_reg.chunk_address - base1_reg) >> bba_pkg::BLK_LOG;
    assign ok0  = off0 < 32'(eff0);
    assign ok1  = off1 < 32'(eff1);

    assign mark        = pool_reg ? rd1_reg : rd0_reg;
    assign issue       = rd_idx_reg < n_reg;
    assign run_inc     = run_reg + IW'(1);
    assign found       = ev_vld_reg && (mark == bba_pkg::MARK_FREE)
                         && (CW'(run_inc) >= CW'(need_reg));
    assign first_c     = ev_idx_reg - run_reg;
    assign is_free_cmd = item_reg.command == bba_pkg::CMD_FREE;
    assign walk_stop   = ev_vld_reg && ((mark == bba_pkg::MARK_FREE) || (mark == bba_pkg::MARK_LAST));
    assign cnt         = ev_idx_reg - first_reg + IW'(1);

    assign base_sel = pool_reg ? base1_reg : base0_reg;
    assign granted  = base_sel + (32'(first_reg) << bba_pkg::BLK_LOG);

    assign sts.clr_busy   = |pend_reg;
    assign sts.scan_found = found;
    assign sts.scan_end   = !ev_vld_reg && !issue;
    assign sts.mark_done  = !(mk_idx_reg < last_reg);
    assign sts.walk_end   = walk_stop || (!ev_vld_reg && !issue);
    assign sts.out_full   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = ev_idx_reg;
        wr_mark = bba_pkg::MARK_FREE;
        case (ctl.op)
            bba_pkg::OP_SCAN:
            begin
                wr_en   = found;
                wr_mark = bba_pkg::MARK_LAST;
            end
            bba_pkg::OP_MARK:
            begin
                wr_en   = mk_idx_reg < last_reg;
                wr_idx  = mk_idx_reg;
                wr_mark = bba_pkg::MARK_TAKEN;
            end
            bba_pkg::OP_WALK:
            begin
                wr_en = ev_vld_reg && is_free_cmd && (mark != bba_pkg::MARK_FREE);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
        we0 = pend_reg[0] || (wr_en && !pool_reg);
        we1 = pend_reg[1] || (wr_en && pool_reg);
        wa0 = pend_reg[0] ? clr_idx_reg : wr_idx[AW-1:0];
        wa1 = pend_reg[1] ? clr_idx_reg : wr_idx[AW-1:0];
        wd0 = pend_reg[0] ? bba_pkg::MARK_FREE : wr_mark;
        wd1 = pend_reg[1] ? bba_pkg::MARK_FREE : wr_mark;
    end

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            mem0[wa0] <= wd0;
        end
        rd0_reg <= mem0[rd_idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            mem1[wa1] <= wd1;
        end
        rd1_reg <= mem1[rd_idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base0_reg   <= '0;
            base1_reg   <= '0;
            blocks0_reg <= '0;
            blocks1_reg <= '0;
            pend_reg    <= 2'b11;
            clr_idx_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    bba_pkg::REG_POOL0_BASE:   base0_reg   <= cfg_data;
                    bba_pkg::REG_POOL0_BLOCKS: blocks0_reg <= cfg_data[bba_pkg::BLKS_W-1:0];
                    bba_pkg::REG_POOL1_BASE:   base1_reg   <= cfg_data;
                    bba_pkg::REG_POOL1_BLOCKS: blocks1_reg <= cfg_data[bba_pkg::BLKS_W-1:0];
                    default:                   base0_reg   <= base0_reg;
                endcase
                pend_reg[cfg_index[1]] <= 1'b1;
                clr_idx_reg            <= '0;
            end
            else if (|pend_reg)
            begin
                if (clr_idx_reg == AW'(MAX_BLOCKS - 1))
                begin
                    pend_reg    <= 2'b00;
                    clr_idx_reg <= '0;
                end
                else
                begin
                    clr_idx_reg <= clr_idx_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ev_vld_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.op == bba_pkg::OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((ctl.op == bba_pkg::OP_SCAN) || (ctl.op == bba_pkg::OP_WALK))
            begin
                ev_vld_reg <= issue;
            end
            else
            begin
                ev_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            bba_pkg::OP_CAPTURE:
            begin
                item_reg   <= in_data;
                pool_reg   <= in_data.want_fast;
                n_reg      <= in_data.want_fast ? eff1 : eff0;
                need_reg   <= need_c;
                rd_idx_reg <= '0;
                run_reg    <= '0;
                first_reg  <= '0;
                bytes_reg  <= '0;
                sts_reg    <= (in_data.command == bba_pkg::CMD_ALLOC) ?
                              bba_pkg::STS_NOSPACE : bba_pkg::STS_OK;
            end
            bba_pkg::OP_LOCATE:
            begin
                if (in0)
                begin
                    pool_reg   <= 1'b0;
                    n_reg      <= ok0 ? eff0 : '0;
                    rd_idx_reg <= ok0 ? IW'(off0) : '0;
                    first_reg  <= IW'(off0);
                    sts_reg    <= ok0 ? bba_pkg::STS_OK : bba_pkg::STS_RANGE;
                end
                else if (in1)
                begin
                    pool_reg   <= 1'b1;
                    n_reg      <= ok1 ? eff1 : '0;
                    rd_idx_reg <= ok1 ? IW'(off1) : '0;
                    first_reg  <= IW'(off1);
                    sts_reg    <= ok1 ? bba_pkg::STS_OK : bba_pkg::STS_RANGE;
                end
                else
                begin
                    n_reg      <= '0;
                    rd_idx_reg <= '0;
                    sts_reg    <= bba_pkg::STS_RANGE;
                end
            end
            bba_pkg::OP_SCAN:
            begin
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + IW'(1);
                end
                ev_idx_reg <= rd_idx_reg;
                if (ev_vld_reg)
                begin
                    if (mark == bba_pkg::MARK_FREE)
                    begin
                        run_reg <= run_inc;
                    end
                    else
                    begin
                        run_reg <= '0;
                    end
                    if (found)
                    begin
                        first_reg  <= first_c;
                        mk_idx_reg <= first_c;
                        last_reg   <= ev_idx_reg;
                        sts_reg    <= bba_pkg::STS_OK;
                    end
                end
            end
            bba_pkg::OP_MARK:
            begin
                if (mk_idx_reg < last_reg)
                begin
                    mk_idx_reg <= mk_idx_reg + IW'(1);
                end
            end
            bba_pkg::OP_WALK:
            begin
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + IW'(1);
                end
                ev_idx_reg <= rd_idx_reg;
                if (ev_vld_reg)
                begin
                    if ((mark == bba_pkg::MARK_FREE) && is_free_cmd)
                    begin
                        sts_reg <= bba_pkg::STS_DOUBLE;
                    end
                    if ((mark == bba_pkg::MARK_LAST) && !is_free_cmd)
                    begin
                        bytes_reg <= bba_pkg::BYTES_W'(32'(cnt) << bba_pkg::BLK_LOG);
                    end
                end
            end
            bba_pkg::OP_RESULT:
            begin
                out_data_reg.status          <= sts_reg;
                out_data_reg.granted_address <= ((item_reg.command == bba_pkg::CMD_ALLOC)
                                                && (sts_reg == bba_pkg::STS_OK)) ? granted : '0;
                out_data_reg.chunk_bytes     <= bytes_reg;
            end
            default:
            begin
                ev_idx_reg <= ev_idx_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/block_bitmap_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Block bitmap allocator
// First-fit allocator over two pools of fixed-size blocks with per-block marks.
// ----------------------------------------------------------------------------
// Allocate scans the chosen pool up to the first free run that fits, then marks
//   that run; with no fit it scans the whole pool. Free and size query walk the
//   chunk's blocks up to the pool end at most, none when out of range; an unused
//   command goes straight to the result. One request at a time: the next is taken
//   once the controller is back in idle; a stalled result holds the controller.
// Reset: a clearing pass frees all marks; any pool register write starts a new
//   pass. No request is taken meanwhile.
module block_bitmap_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  bba_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  wire                           out_ready,
    output bba_pkg::out_t                 out_data,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [bba_pkg::ADDR_W-1:0]     cfg_data
);

    bba_pkg::ctl_t    ctl;
    bba_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_cmd   (in_data.command),
        .sts      (sts),
        .ctl      (ctl)
    );

    bba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .ctl       (ctl),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire

[hdl/bba_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Block bitmap allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           in_valid,
    input wire                           in_ready,
    input wire                           out_valid,
    input wire                           out_ready,
    input bba_pkg::out_t                 out_data,
    input wire                           cfg_valid,
    input wire                           cfg_ready
);

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in flight");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("request taken during mark clearing");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != bba_pkg::STS_OK) |->
        (out_data.granted_address == '0) && (out_data.chunk_bytes == '0))
        else $error("failed result carries data");

    a_grant_no_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.granted_address != '0) |-> (out_data.chunk_bytes == '0))
        else $error("grant carries a size");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (.*);
`default_nettype wire
